// ----- rtl/kgc_pkg.sv -----
// Package for the keyed group collector: operation and status codes,
// the classified command passed from front to back, and the result record.
// No dependencies.
`default_nettype none

package kgc_pkg;

	localparam int KEY_W    = 8;
	localparam int HANDLE_W = 16;
	localparam int SLOT_W   = 8;
	localparam int MEMBER_W = 4;
	localparam int TOTAL_W  = 9;
	localparam int MCOUNT_W = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_QCOUNT  = 2'd2,
		OP_QMEMBER = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic                key_ok;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] item_handle;
		logic [SLOT_W-1:0]   slot_index;
		logic [MEMBER_W-1:0] member_index;
	} cmd_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]  group_total;
		logic [MCOUNT_W-1:0] member_total;
		logic [HANDLE_W-1:0] member_handle;
		logic [KEY_W-1:0]    group_key;
		status_t             status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/kgc_if.sv -----
// Request and response channel interfaces of the keyed group collector.
// Depends on nothing; field widths follow the block's item layout.
`default_nettype none

interface kgc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  key;
	logic [15:0] item_handle;
	logic [7:0]  slot_index;
	logic [3:0]  member_index;

	modport source (output valid, output op, output key, output item_handle,
		output slot_index, output member_index, input ready);
	modport sink (input valid, input op, input key, input item_handle,
		input slot_index, input member_index, output ready);
endinterface

interface kgc_rsp_if;
	logic        valid;
	logic        ready;
	logic [8:0]  group_total;
	logic [4:0]  member_total;
	logic [15:0] member_handle;
	logic [7:0]  group_key;
	logic [1:0]  status;

	modport source (output valid, output group_total, output member_total,
		output member_handle, output group_key, output status, input ready);
	modport sink (input valid, input group_total, input member_total,
		input member_handle, input group_key, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/kgc_front.sv -----
// Front end: accepts request items, classifies them into commands and
// registers them for the queue. Depends on kgc_pkg and kgc_req_if.
`default_nettype none

module kgc_front
	import kgc_pkg::*;
#(
	parameter int NUM_KEYS = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kgc_req_if.sink     req,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  wire logic   cmd_ready
);

	cmd_t cmd_s1;
	logic valid_s1;
	logic take;

	assign req.ready = !valid_s1 || cmd_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: decode op, check key against the key range
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op           <= op_t'(req.op);
			cmd_s1.key_ok       <= (32'(req.key) < 32'(NUM_KEYS));
			cmd_s1.key          <= req.key;
			cmd_s1.item_handle  <= req.item_handle;
			cmd_s1.slot_index   <= req.slot_index;
			cmd_s1.member_index <= req.member_index;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

// ----- rtl/kgc_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on kgc_pkg.
`default_nettype none

module kgc_queue
	import kgc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  push_cmd,
	input  wire logic  push_valid,
	output logic       push_ready,
	output cmd_t       pop_cmd,
	output logic       pop_valid,
	input  wire logic  pop_ready
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ----- rtl/kgc_back.sv -----
// Back end: owns the key map, slot tables and member store, executes one
// command at a time and holds the response register.
// Depends on kgc_pkg and kgc_rsp_if.
`default_nettype none

module kgc_back
	import kgc_pkg::*;
#(
	parameter int NUM_KEYS    = 256,
	parameter int MAX_MEMBERS = 16,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	kgc_rsp_if.source  rsp
);

	// only keys below 2**KEY_W can arrive, so no more slots than that are used
	localparam int KEY_DEPTH   = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
	localparam int KIW         = $clog2(KEY_DEPTH);
	localparam int SU_W        = $clog2(KEY_DEPTH + 1);
	localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
	// member positions beyond the member index range are never read back
	localparam int MEM_DEPTH   = (MAX_MEMBERS < (1 << MEMBER_W)) ? MAX_MEMBERS
	                                                              : (1 << MEMBER_W);
	localparam int MIW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int STORE_DEPTH = KEY_DEPTH * MEM_DEPTH;
	localparam int SAW         = $clog2(STORE_DEPTH);
	localparam int HW          = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	// tables
	logic [KIW-1:0]   slot_of_key_mem [KEY_DEPTH];
	logic [CNT_W-1:0] cnt_by_key_mem  [KEY_DEPTH];
	logic [KEY_W-1:0] key_of_slot_mem [KEY_DEPTH];
	logic [CNT_W-1:0] cnt_by_slot_mem [KEY_DEPTH];
	logic [HW-1:0]    store_mem       [STORE_DEPTH];

	logic [KEY_DEPTH-1:0] key_seen_q;
	logic [SU_W-1:0]      slots_used_q;

	// execute stage
	cmd_t             cmd_s2;
	logic             exec_v_s2;
	logic [KIW-1:0]   sok_rd_s2;
	logic [CNT_W-1:0] cbk_rd_s2;
	logic [KEY_W-1:0] kos_rd_s2;
	logic [CNT_W-1:0] cbs_rd_s2;
	logic [HW-1:0]    store_rd_s2;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic             issue;
	logic [SAW-1:0]   store_rd_addr;
	logic [KIW-1:0]   key_idx;
	logic [KIW-1:0]   new_slot;
	logic             seen;
	logic             slots_full;
	logic             slot_ok;
	logic [CNT_W-1:0] cnt_next;
	logic             new_key;
	logic             append;
	logic             do_clear;
	logic             store_we;
	logic [SAW-1:0]   store_wr_addr;
	logic [KIW-1:0]   cbs_wr_addr;
	logic [CNT_W-1:0] cnt_wr_data;
	rsp_t             res;

	// one command in execution at a time; issue only when the response
	// register will be free when the command finishes
	assign issue     = cmd_valid && !exec_v_s2 && (!rsp_valid_q || rsp.ready);
	assign cmd_ready = issue;

	assign store_rd_addr = SAW'(SAW'(cmd.slot_index[KIW-1:0]) * SAW'(MEM_DEPTH))
		+ SAW'(cmd.member_index[MIW-1:0]);

	// registered table reads
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s2      <= cmd;
			sok_rd_s2   <= slot_of_key_mem[cmd.key[KIW-1:0]];
			cbk_rd_s2   <= cnt_by_key_mem[cmd.key[KIW-1:0]];
			kos_rd_s2   <= key_of_slot_mem[cmd.slot_index[KIW-1:0]];
			cbs_rd_s2   <= cnt_by_slot_mem[cmd.slot_index[KIW-1:0]];
			store_rd_s2 <= store_mem[store_rd_addr];
		end
	end

	assign key_idx    = cmd_s2.key[KIW-1:0];
	assign new_slot   = slots_used_q[KIW-1:0];
	assign seen       = key_seen_q[key_idx];
	assign slots_full = (slots_used_q == SU_W'(KEY_DEPTH));
	assign slot_ok    = ({1'b0, cmd_s2.slot_index} < TOTAL_W'(slots_used_q));
	assign cnt_next   = CNT_W'(cbk_rd_s2 + 1'b1);

	always_comb begin
		res               = '0;
		res.group_total   = TOTAL_W'(slots_used_q);
		res.status        = ST_OK;
		new_key           = 1'b0;
		append            = 1'b0;
		do_clear          = 1'b0;
		store_we          = 1'b0;
		store_wr_addr     = '0;
		cbs_wr_addr       = new_slot;
		cnt_wr_data       = CNT_W'(1);
		case (cmd_s2.op)
			OP_ADD: begin
				if (!cmd_s2.key_ok) begin
					res.status = ST_FULL;
				end else if (!seen) begin
					res.group_key = cmd_s2.key;
					if (slots_full) begin
						res.status = ST_FULL;
					end else begin
						new_key          = 1'b1;
						store_we         = 1'b1;
						store_wr_addr    = SAW'(SAW'(new_slot) * SAW'(MEM_DEPTH));
						res.group_total  = TOTAL_W'(SU_W'(slots_used_q + 1'b1));
						res.member_total = MCOUNT_W'(1);
					end
				end else begin
					res.group_key = cmd_s2.key;
					if (cbk_rd_s2 >= CNT_W'(MAX_MEMBERS)) begin
						res.status       = ST_FULL;
						res.member_total = MCOUNT_W'(cbk_rd_s2);
					end else begin
						append           = 1'b1;
						cbs_wr_addr      = sok_rd_s2;
						cnt_wr_data      = cnt_next;
						store_we         = (cbk_rd_s2 < CNT_W'(MEM_DEPTH));
						store_wr_addr    = SAW'(SAW'(sok_rd_s2) * SAW'(MEM_DEPTH))
							+ SAW'(cbk_rd_s2[MIW-1:0]);
						res.member_total = MCOUNT_W'(cnt_next);
					end
				end
			end
			OP_CLEAR: begin
				do_clear        = 1'b1;
				res.group_total = '0;
			end
			default: begin
				if (!slot_ok) begin
					res.status = ST_RANGE;
				end else begin
					res.member_total = MCOUNT_W'(cbs_rd_s2);
					res.group_key    = kos_rd_s2;
					if (cmd_s2.op == OP_QMEMBER) begin
						if ((32'(cmd_s2.member_index) >= 32'(cbs_rd_s2))
							|| (32'(cmd_s2.member_index) >= 32'(MAX_MEMBERS))) begin
							res.status = ST_RANGE;
						end else begin
							res.member_handle = HANDLE_W'(store_rd_s2);
						end
					end
				end
			end
		endcase
	end

	// table writes
	always_ff @(posedge clk) begin
		if (exec_v_s2) begin
			if (new_key) begin
				slot_of_key_mem[key_idx]  <= new_slot;
				key_of_slot_mem[new_slot] <= cmd_s2.key;
			end
			if (new_key || append) begin
				cnt_by_key_mem[key_idx]      <= cnt_wr_data;
				cnt_by_slot_mem[cbs_wr_addr] <= cnt_wr_data;
			end
			if (store_we) store_mem[store_wr_addr] <= cmd_s2.item_handle[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_v_s2    <= 1'b0;
			rsp_valid_q  <= 1'b0;
			key_seen_q   <= '0;
			slots_used_q <= '0;
		end else begin
			exec_v_s2 <= issue;
			if (exec_v_s2) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (exec_v_s2 && do_clear) begin
				key_seen_q   <= '0;
				slots_used_q <= '0;
			end else if (exec_v_s2 && new_key) begin
				key_seen_q[key_idx] <= 1'b1;
				slots_used_q        <= SU_W'(slots_used_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_v_s2) rsp_q <= res;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.group_total   = rsp_q.group_total;
	assign rsp.member_total  = rsp_q.member_total;
	assign rsp.member_handle = rsp_q.member_handle;
	assign rsp.group_key     = rsp_q.group_key;
	assign rsp.status        = rsp_q.status;

endmodule

`default_nettype wire

// ----- rtl/keyed_group_collector.sv -----
// Keyed group collector: groups item handles by key into dense slots.
// Channels: req (sink) takes one command item per handshake (add, clear,
// slot count query, member query); rsp (source) returns exactly one result
// item per command, in command order. Both use valid/ready; an item moves
// at a rising clk edge where valid and ready are both high.
// Path: a command passes the front register, the queue, the table read
// register and the execute stage into the rsp register before its result
// is offered on rsp.
// The back end takes one command at a time: it reads its tables into a
// register and writes them back before it accepts another command, and
// it issues only while the rsp register will be free.
// The front register and a two-entry queue keep req accepting while the
// back end works or a result waits; when rsp stalls, the back end holds
// and the queue fills, then req.ready drops. No item is lost or repeated.
// Reset (arst_n low) forgets all keys and empties the pipeline; the slot
// tables and member store hold no reset value and are only read where a
// key or slot is in use. Depends on kgc_pkg, kgc_if, kgc_front, kgc_queue
// and kgc_back.
`default_nettype none

module keyed_group_collector
	import kgc_pkg::*;
#(
	parameter int NUM_KEYS    = 256,
	parameter int MAX_MEMBERS = 16,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kgc_req_if.sink   req,
	kgc_rsp_if.source rsp
);

	// front to queue
	cmd_t fq_cmd;
	logic fq_valid;
	logic fq_ready;

	// queue to back
	cmd_t qb_cmd;
	logic qb_valid;
	logic qb_ready;

	// accept and classify: op decode and key range check
	kgc_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (fq_cmd),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready)
	);

	// decouple: let the front keep accepting while the back end is busy
	kgc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (fq_cmd),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.pop_cmd    (qb_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready)
	);

	// execute against the key map, slot tables and member store
	kgc_back #(
		.NUM_KEYS    (NUM_KEYS),
		.MAX_MEMBERS (MAX_MEMBERS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (qb_cmd),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
